// ===== hdl/ipv4dp_pkg.sv =====
// Shared types and constants for the IPv4 dotted-decimal parser.
// No dependencies; every other file in hdl/ imports this package.
package ipv4dp_pkg;

    // Default and legal range of the string length limit.
    localparam int MAX_CHARS_DEF = 15;
    localparam int MAX_CHARS_MIN = 7;
    localparam int MAX_CHARS_MAX = 31;

    // Depth of the queue between the classifier and the parser core.
    localparam int QUEUE_DEPTH = 2;

    // Character codes.
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam logic [9:0] OCTET_MAX  = 10'd255;
    localparam logic [1:0] FIELD_LAST = 2'd3;   // last dot count / digit count

    // Input word: one character of the string.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_in_word;

    // Output word: verdict and address.
    typedef struct packed {
        logic        valid_res;
        logic [31:0] address;
    } t_out_word;

    // Classified character, as held in the queue.
    typedef struct packed {
        logic       is_ws;
        logic       is_dot;
        logic       is_digit;
        logic [3:0] digit;
        logic       last;
    } t_cls;

endpackage

// ===== hdl/ipv4dp_front.sv =====
// Character classifier: whitespace, dot, digit and digit value.
// Depends on ipv4dp_pkg.
module ipv4dp_front
    import ipv4dp_pkg::*;
(
    input  t_in_word i_word,
    output t_cls     o_cls
);

    logic [7:0] w_diff;

    assign w_diff = i_word.ch - CH_ZERO;

    always_comb begin
        o_cls.is_ws    = (i_word.ch == CH_SPACE) ||
                         ((i_word.ch >= CH_TAB) && (i_word.ch <= CH_CR));
        o_cls.is_dot   = (i_word.ch == CH_DOT);
        o_cls.is_digit = (i_word.ch >= CH_ZERO) && (i_word.ch <= CH_NINE);
        o_cls.digit    = w_diff[3:0];
        o_cls.last     = i_word.last;
    end

endmodule

// ===== hdl/ipv4dp_queue.sv =====
// Short FIFO of classified characters between classifier and parser core.
// Depends on ipv4dp_pkg.
module ipv4dp_queue
    import ipv4dp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cls i_cls,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cls o_cls
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cls             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic w_push, w_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cls   = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    function automatic logic [PTR_W-1:0] f_next(input logic [PTR_W-1:0] p);
        f_next = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= f_next(r_wr_ptr);
            end
            if (w_pop) begin
                r_rd_ptr <= f_next(r_rd_ptr);
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== hdl/ipv4dp_back.sv =====
// Parser core: octet accumulation, error tracking and result register.
// Depends on ipv4dp_pkg.
module ipv4dp_back
    import ipv4dp_pkg::*;
#(
    parameter int MAX_CHARS = MAX_CHARS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_cls      i_cls,
    output logic      o_pop,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_word o_word
);

    localparam int CC_W = $clog2(MAX_CHARS + 1);

    typedef enum logic [1:0] {
        PH_LEAD,
        PH_ADDR,
        PH_TRAIL
    } t_phase;

    t_phase      r_phase,   n_phase;
    logic [9:0]  r_octet,   n_octet;
    logic [1:0]  r_digits,  n_digits;
    logic [1:0]  r_dots,    n_dots;
    logic        r_prevdot, n_prevdot;
    logic [31:0] r_addr,    n_addr;
    logic        r_err,     n_err;
    logic [CC_W-1:0] r_cc,  n_cc;
    logic        r_out_valid;
    t_out_word   r_out,     n_out;

    t_phase      w_ph;

    assign o_pop   = i_valid && (!i_cls.last || !r_out_valid || !i_stall);
    assign o_valid = r_out_valid;
    assign o_word  = r_out;

    always_comb begin
        n_phase   = r_phase;
        n_octet   = r_octet;
        n_digits  = r_digits;
        n_dots    = r_dots;
        n_prevdot = r_prevdot;
        n_addr    = r_addr;
        n_err     = r_err;
        n_cc      = r_cc;
        n_out     = '0;
        w_ph      = r_phase;

        if (r_cc >= CC_W'(MAX_CHARS)) begin
            n_err = 1'b1;
        end else begin
            n_cc = r_cc + 1'b1;
        end

        if (!n_err) begin
            if (r_phase == PH_LEAD && !i_cls.is_ws) begin
                w_ph = PH_ADDR;
            end
            n_phase = w_ph;
            case (w_ph)
                PH_ADDR: begin
                    if (i_cls.is_dot) begin
                        if (r_prevdot || r_dots == FIELD_LAST || r_octet > OCTET_MAX) begin
                            n_err = 1'b1;
                        end else begin
                            // first octet lands in the top byte
                            n_addr    = r_addr | (32'(r_octet[7:0]) << {~r_dots, 3'b000});
                            n_dots    = r_dots + 1'b1;
                            n_octet   = '0;
                            n_digits  = '0;
                            n_prevdot = 1'b1;
                        end
                    end else if (i_cls.is_digit) begin
                        if (r_digits == FIELD_LAST) begin
                            n_err = 1'b1;
                        end else begin
                            n_octet   = (r_octet << 3) + (r_octet << 1) + 10'(i_cls.digit);
                            n_digits  = r_digits + 1'b1;
                            n_prevdot = 1'b0;
                        end
                    end else begin
                        if (r_prevdot) begin
                            n_err = 1'b1;
                        end else begin
                            // address ends: close the open octet
                            if (r_octet > OCTET_MAX) begin
                                n_err = 1'b1;
                            end else begin
                                n_addr = r_addr | 32'(r_octet[7:0]);
                            end
                            n_phase = PH_TRAIL;
                            if (!i_cls.is_ws) begin
                                n_err = 1'b1;
                            end
                        end
                    end
                end
                PH_TRAIL: begin
                    if (!i_cls.is_ws) begin
                        n_err = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end

        if (i_cls.last) begin
            if (!n_err && n_phase != PH_TRAIL) begin
                if (n_octet > OCTET_MAX) begin
                    n_err = 1'b1;
                end else begin
                    n_addr = n_addr | 32'(n_octet[7:0]);
                end
            end
            n_out.valid_res = !n_err && (n_dots == FIELD_LAST);
            n_out.address   = n_out.valid_res ? n_addr : '0;
            // back to the reset state for the next string
            n_phase   = PH_LEAD;
            n_octet   = '0;
            n_digits  = '0;
            n_dots    = '0;
            n_prevdot = 1'b0;
            n_addr    = '0;
            n_err     = 1'b0;
            n_cc      = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_LEAD;
            r_octet     <= '0;
            r_digits    <= '0;
            r_dots      <= '0;
            r_prevdot   <= 1'b0;
            r_addr      <= '0;
            r_err       <= 1'b0;
            r_cc        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase   <= n_phase;
                r_octet   <= n_octet;
                r_digits  <= n_digits;
                r_dots    <= n_dots;
                r_prevdot <= n_prevdot;
                r_addr    <= n_addr;
                r_err     <= n_err;
                r_cc      <= n_cc;
            end
            if (o_pop && i_cls.last) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_cls.last) begin
            r_out <= n_out;
        end
    end

endmodule

// ===== hdl/ipv4_dotted_decimal_parser.sv =====
// IPv4 dotted-decimal parser. Takes one character word per cycle while not
// stalled, with a flag on the final character, and gives one output word per
// string: a valid flag and the 32-bit address (first octet in the top byte,
// zero when invalid). Leading whitespace is skipped, four octets of at most
// three digits each (each at most 255) must be read, and only whitespace may
// follow the address; an empty first or last octet counts as zero, but two
// dots in a row are invalid. A string longer than MAX_CHARS characters is
// invalid. Throughput is one character per cycle while the result output is
// not stalled; the parser core does the octet update (multiply by ten and
// add) and loads its result register when the final character is taken. A
// two-entry queue separates the classifier from the core, and the result
// register lets non-final characters flow in while a result waits to be taken.
// Depends on ipv4dp_pkg, ipv4dp_front, ipv4dp_queue and ipv4dp_back.
module ipv4_dotted_decimal_parser
    import ipv4dp_pkg::*;
#(
    parameter int MAX_CHARS = MAX_CHARS_DEF   // 7 .. 31
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    // character words in
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_word  i_data,
    // result words out
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_word o_data
);

    t_cls w_cls_in;
    t_cls w_cls_q;
    logic w_q_full;
    logic w_q_valid;
    logic w_pop;

    // stall depends on queue occupancy only, never on i_valid
    assign o_stall = w_q_full;

    ipv4dp_front u_front (
        .i_word (i_data),
        .o_cls  (w_cls_in)
    );

    ipv4dp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_valid),
        .i_cls   (w_cls_in),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_cls   (w_cls_q)
    );

    ipv4dp_back #(
        .MAX_CHARS (MAX_CHARS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .i_cls   (w_cls_q),
        .o_pop   (w_pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_word  (o_data)
    );

endmodule
